/* src/b58enc_pkg.sv */
// Shared constants and the digit-to-character map for the Base58 encoder.
`timescale 1ns / 1ps
`default_nettype none

package b58enc_pkg;

    // Default buffer sizes.
    localparam int DEF_MAX_BYTES = 32;
    localparam int DEF_MAX_CHARS = 44;

    // Base of the output number system.
    localparam logic [13:0] RADIX = 14'd58;

    // Reciprocal of 58 scaled by 2**20, rounded up. It gives the exact
    // quotient for every dividend below 58 * 256.
    localparam logic [28:0] DIV_MULT  = 29'd18079;
    localparam int          DIV_SHIFT = 20;

    // Character sent for each leading zero byte.
    localparam logic [6:0] ZERO_CHAR = 7'd49;

    // Map a base-58 digit to its alphabet character. The alphabet skips
    // the characters 0, I, O and l.
    function automatic logic [6:0] b58_char(input logic [5:0] digit);
        logic [6:0] d;
        d = {1'b0, digit};
        if (digit < 6'd9)
            return 7'd49 + d;            // 1 .. 9
        else if (digit < 6'd17)
            return 7'd65 + d - 7'd9;     // A .. H
        else if (digit < 6'd22)
            return 7'd74 + d - 7'd17;    // J .. N
        else if (digit < 6'd33)
            return 7'd80 + d - 7'd22;    // P .. Z
        else if (digit < 6'd44)
            return 7'd97 + d - 7'd33;    // a .. k
        else
            return 7'd109 + d - 7'd44;   // m .. z
    endfunction

endpackage

`default_nettype wire

/* src/base58_encoder.sv */
// Base58 encoder: byte stream in, alphabet character stream out.
`timescale 1ns / 1ps
`default_nettype none

// Bytes of one message enter one per cycle while the block collects them;
// the byte flagged with tlast starts the conversion, and the block takes no
// input until the last character of the encoding has been transferred. Up to
// MAX_BYTES bytes are kept; further bytes are dropped and every character of
// that message carries overflow in tuser. Conversion runs one shared
// divide-by-58 unit over the stored number, one byte per cycle; each pass
// yields one digit, and leading zero quotient bytes are trimmed after every
// pass. The digits then leave most significant first, after one '1' per
// leading zero byte, each held until the output side is ready.
module base58_encoder #(
    parameter int MAX_BYTES = b58enc_pkg::DEF_MAX_BYTES,
    parameter int MAX_CHARS = b58enc_pkg::DEF_MAX_CHARS
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // Input stream.
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  wire logic       s_axis_tlast,   // last_byte
    // Output stream.
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [6:0] char_code, [7] zero
    output logic            m_axis_tlast,   // last_char
    output logic            m_axis_tuser    // [0] overflow
);

    import b58enc_pkg::*;

    localparam int CW  = $clog2(MAX_BYTES + 1);
    localparam int AW  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int NW  = $clog2(MAX_CHARS + 1);
    localparam int DAW = $clog2(MAX_CHARS);
    localparam int SW  = ((CW > NW) ? CW : NW) + 1;

    localparam logic [CW-1:0] MAX_BYTES_C = CW'(MAX_BYTES);
    localparam logic [NW-1:0] MAX_CHARS_N = NW'(MAX_CHARS);
    localparam logic [SW-1:0] MAX_CHARS_S = SW'(MAX_CHARS);

    typedef enum logic [7:0] {
        IDLE       = 8'b0000_0001,
        CONV_SETUP = 8'b0000_0010,
        PASS_START = 8'b0000_0100,
        PASS_RUN   = 8'b0000_1000,
        EMIT_SETUP = 8'b0001_0000,
        EMIT_PICK  = 8'b0010_0000,
        DIG_LOAD   = 8'b0100_0000,
        OUT_WAIT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Message bookkeeping.
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] zp_reg, zp_next;
    logic          nonzero_reg, nonzero_next;
    logic          dropped_reg, dropped_next;

    // Division sequencing.
    logic [CW-1:0] head_reg, head_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [5:0]    rem_reg, rem_next;
    logic          found_reg, found_next;
    logic [AW-1:0] new_head_reg, new_head_next;
    logic [NW-1:0] nd_reg, nd_next;

    // Output sequencing.
    logic [NW-1:0] ones_reg, ones_next;
    logic [NW-1:0] left_reg, left_next;
    logic [NW-1:0] k_reg, k_next;
    logic          out_valid_reg, out_valid_next;
    logic [6:0]    out_char_reg, out_char_next;
    logic          out_last_reg, out_last_next;

    // Byte memory ports.
    logic [7:0]    byte_mem [MAX_BYTES];
    logic          byte_we;
    logic [AW-1:0] byte_waddr;
    logic [7:0]    byte_wdata;
    logic          byte_re;
    logic [AW-1:0] byte_raddr;
    logic [7:0]    byte_rdata_reg;

    // Digit memory ports.
    logic [5:0]     digit_mem [MAX_CHARS];
    logic           digit_we;
    logic           digit_re;
    logic [DAW-1:0] digit_raddr;
    logic [5:0]     digit_rdata_reg;

    // Shared divide-by-58 unit and its derived values.
    logic [13:0]   dividend;
    logic [28:0]   product;
    logic [7:0]    quot;
    logic [13:0]   rem_full;
    logic [CW-1:0] idx_ext;
    logic [CW-1:0] idx_inc;
    logic [CW-1:0] head_after;
    logic [NW-1:0] nd_after;
    logic [SW-1:0] zp_s;
    logic [SW-1:0] ones_s;
    logic [SW-1:0] total_s;

    always_comb
    begin
        dividend = {rem_reg, byte_rdata_reg};
        product  = 29'(dividend) * DIV_MULT;
        quot     = product[DIV_SHIFT +: 8];
        rem_full = dividend - 14'(quot) * RADIX;
    end

    always_comb
    begin
        idx_ext  = CW'(idx_reg);
        idx_inc  = idx_ext + CW'(1);
        nd_after = nd_reg + NW'(1);
        if (found_reg)
            head_after = CW'(new_head_reg);
        else if (quot != 8'd0)
            head_after = idx_ext;
        else
            head_after = count_reg;
        zp_s    = SW'(zp_reg);
        ones_s  = (zp_s > MAX_CHARS_S) ? MAX_CHARS_S : zp_s;
        total_s = ones_s + SW'(nd_reg);
        if (total_s > MAX_CHARS_S)
            total_s = MAX_CHARS_S;
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        zp_next        = zp_reg;
        nonzero_next   = nonzero_reg;
        dropped_next   = dropped_reg;
        head_next      = head_reg;
        idx_next       = idx_reg;
        rem_next       = rem_reg;
        found_next     = found_reg;
        new_head_next  = new_head_reg;
        nd_next        = nd_reg;
        ones_next      = ones_reg;
        left_next      = left_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        byte_we        = 1'b0;
        byte_waddr     = count_reg[AW-1:0];
        byte_wdata     = s_axis_tdata;
        byte_re        = 1'b0;
        byte_raddr     = idx_reg;
        digit_we       = 1'b0;
        digit_re       = 1'b0;
        digit_raddr    = DAW'(k_reg - NW'(1));

        unique case (state_reg)
            IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (count_reg < MAX_BYTES_C)
                    begin
                        byte_we    = 1'b1;
                        count_next = count_reg + CW'(1);
                        if (!nonzero_reg && s_axis_tdata == 8'd0)
                            zp_next = zp_reg + CW'(1);
                        else
                            nonzero_next = 1'b1;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (s_axis_tlast)
                        state_next = CONV_SETUP;
                end
            end

            CONV_SETUP:
            begin
                nd_next   = '0;
                head_next = zp_reg;
                if (zp_reg >= count_reg)
                    state_next = EMIT_SETUP;
                else
                    state_next = PASS_START;
            end

            PASS_START:
            begin
                byte_re    = 1'b1;
                byte_raddr = head_reg[AW-1:0];
                idx_next   = head_reg[AW-1:0];
                rem_next   = '0;
                found_next = 1'b0;
                state_next = PASS_RUN;
            end

            PASS_RUN:
            begin
                // Write the quotient byte back in place.
                byte_we    = 1'b1;
                byte_waddr = idx_reg;
                byte_wdata = quot;
                rem_next   = rem_full[5:0];
                if (!found_reg && quot != 8'd0)
                begin
                    found_next    = 1'b1;
                    new_head_next = idx_reg;
                end
                if (idx_inc < count_reg)
                begin
                    byte_re    = 1'b1;
                    byte_raddr = idx_inc[AW-1:0];
                    idx_next   = idx_inc[AW-1:0];
                end
                else
                begin
                    // End of a pass: the remainder is the next digit.
                    digit_we  = 1'b1;
                    nd_next   = nd_after;
                    head_next = head_after;
                    if (head_after < count_reg && nd_after < MAX_CHARS_N)
                        state_next = PASS_START;
                    else
                        state_next = EMIT_SETUP;
                end
            end

            EMIT_SETUP:
            begin
                ones_next  = NW'(ones_s);
                left_next  = NW'(total_s);
                k_next     = nd_reg;
                state_next = EMIT_PICK;
            end

            EMIT_PICK:
            begin
                if (left_reg == '0)
                begin
                    count_next   = '0;
                    zp_next      = '0;
                    nonzero_next = 1'b0;
                    dropped_next = 1'b0;
                    state_next   = IDLE;
                end
                else if (ones_reg != '0)
                begin
                    ones_next      = ones_reg - NW'(1);
                    out_valid_next = 1'b1;
                    out_char_next  = ZERO_CHAR;
                    out_last_next  = (left_reg == NW'(1));
                    state_next     = OUT_WAIT;
                end
                else
                begin
                    digit_re   = 1'b1;
                    k_next     = k_reg - NW'(1);
                    state_next = DIG_LOAD;
                end
            end

            DIG_LOAD:
            begin
                out_valid_next = 1'b1;
                out_char_next  = b58_char(digit_rdata_reg);
                out_last_next  = (left_reg == NW'(1));
                state_next     = OUT_WAIT;
            end

            OUT_WAIT:
            begin
                if (m_axis_tready)
                begin
                    out_valid_next = 1'b0;
                    left_next      = left_reg - NW'(1);
                    state_next     = EMIT_PICK;
                end
            end

            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            count_reg     <= '0;
            zp_reg        <= '0;
            nonzero_reg   <= 1'b0;
            dropped_reg   <= 1'b0;
            head_reg      <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            nd_reg        <= '0;
            ones_reg      <= '0;
            left_reg      <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            zp_reg        <= zp_next;
            nonzero_reg   <= nonzero_next;
            dropped_reg   <= dropped_next;
            head_reg      <= head_next;
            idx_reg       <= idx_next;
            found_reg     <= found_next;
            nd_reg        <= nd_next;
            ones_reg      <= ones_next;
            left_reg      <= left_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        new_head_reg <= new_head_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    // Byte memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (byte_we)
            byte_mem[byte_waddr] <= byte_wdata;
        if (byte_re)
            byte_rdata_reg <= byte_mem[byte_raddr];
    end

    // Digit memory: written at the end of each pass, read while emitting.
    always_ff @(posedge clk)
    begin
        if (digit_we)
            digit_mem[nd_reg[DAW-1:0]] <= rem_full[5:0];
        if (digit_re)
            digit_rdata_reg <= digit_mem[digit_raddr];
    end

    // Port drive.
    assign s_axis_tready = (state_reg == IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_char_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = dropped_reg;

    // Checks on the sequencer.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input accepted while a character is pending");

    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input still open after the final byte");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_BYTES_C && zp_reg <= count_reg)
        else $error("byte count out of range");

    a_pass_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == PASS_RUN) |-> (idx_ext < count_reg && nd_reg < MAX_CHARS_N))
        else $error("division pass beyond the stored message");

    a_final_char: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (left_reg == '0))
        else $error("last character sent with characters still pending");

endmodule

`default_nettype wire
